### hdl/wfcf_pkg.sv
// Package for the wifi frame capture filter.
// Holds shared constants, register indexes and the controller/datapath structs.
// No dependencies.
package wfcf_pkg;

  localparam logic       REG_CAPTURE_MODE = 1'b0;
  localparam logic       REG_SNAP_LENGTH  = 1'b1;

  localparam logic [2:0] MODE_RAW   = 3'd0;
  localparam logic [2:0] MODE_BEACON = 3'd1;
  localparam logic [2:0] MODE_PROBE = 3'd2;
  localparam logic [2:0] MODE_EAPOL = 3'd3;
  localparam logic [2:0] MODE_PMKID = 3'd4;

  localparam logic [2:0]  MODE_RESET = MODE_RAW;
  localparam logic [15:0] SNAP_RESET = 16'hFFFF;

  localparam logic [1:0] TYPE_MGMT = 2'd0;
  localparam logic [1:0] TYPE_DATA = 2'd2;

  localparam logic [3:0] SUB_PROBE_REQ = 4'h4;
  localparam logic [3:0] SUB_BEACON    = 4'h8;
  localparam logic [3:0] SUB_DEAUTH    = 4'hC;

  localparam logic [15:0] EAPOL_ETHERTYPE = 16'h888E;
  localparam logic [15:0] KEY_ACK_MASK    = 16'h0080;
  localparam logic [15:0] KEY_MIC_MASK    = 16'h0100;

  localparam logic [5:0] HDR_THREE_ADDR = 6'd24;
  localparam logic [5:0] HDR_FOUR_ADDR  = 6'd30;
  localparam logic [5:0] HDR_QOS_EXTRA  = 6'd2;
  localparam logic [5:0] LLC_SNAP_BYTES = 6'd8;
  localparam logic [5:0] KEY_MIN_BYTES  = 6'd7;

  typedef struct packed {
    logic latch;
    logic idx_clear;
    logic idx_inc;
    logic set_open;
    logic clr_open;
    logic m1_write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic follow;
    logic is_m1;
    logic hit;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

### hdl/wfcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wfcf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/wfcf_ctrl.sv
// Controller state machine of the capture filter.
// Depends on wfcf_pkg for the command and status structs.
module wfcf_ctrl import wfcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_READ   = 5'b00100,
    S_CMP    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.follow) begin
          cmd.idx_clear = 1'b1;
          state_next = S_READ;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (st.hit) begin
          cmd.set_open = st.is_m1;
          cmd.clr_open = !st.is_m1;
          state_next = S_FINISH;
        end else if (st.idx_last) begin
          cmd.m1_write = st.is_m1;
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/wfcf_datapath.sv
// Datapath of the capture filter: registers, session table, counters, result register.
// Depends on wfcf_pkg and wfcf_ram.
module wfcf_datapath import wfcf_pkg::*; #(
  parameter int SESSION_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  frame_type,
  input  logic [3:0]  frame_subtype,
  input  logic        to_distribution,
  input  logic        from_distribution,
  input  logic [47:0] address_one,
  input  logic [47:0] address_two,
  input  logic [11:0] frame_length,
  input  logic [15:0] llc_ethertype,
  input  logic [15:0] key_word,
  input  logic        pmkid_present,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        keep_frame,
  output logic [15:0] capture_length,
  output logic [31:0] deauth_total,
  output logic [31:0] captured_total,
  output logic        handshake_seen,
  output logic [47:0] handshake_ap
);

  localparam int IDX_W = $clog2(SESSION_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SESSION_SLOTS - 1);

  logic [2:0]  capture_mode;
  logic [15:0] snap_length;

  logic [1:0]  f_type;
  logic [3:0]  f_sub;
  logic        f_to_ds;
  logic        f_from_ds;
  logic [47:0] f_a1;
  logic [47:0] f_a2;
  logic [11:0] f_len;
  logic [15:0] f_etype;
  logic [15:0] f_info;
  logic        f_pmkid;

  logic [31:0] kept_count;
  logic [31:0] deauth_count;
  logic        handshake_flag;
  logic [47:0] handshake_address;
  logic [IDX_W-1:0] slot_ptr;
  logic [IDX_W-1:0] idx;
  logic [SESSION_SLOTS-1:0] slot_valid;
  logic [SESSION_SLOTS-1:0] slot_open;

  logic [5:0]  hlen;
  logic        eapol_ok;
  logic        key_ok;
  logic        ack;
  logic        mic;
  logic        is_m1;
  logic        is_m2;
  logic        keep;
  logic        deauth;
  logic [47:0] ap;
  logic [47:0] sta;
  logic [95:0] rd_data;
  logic        addr_match;
  logic [31:0] kept_next;
  logic [31:0] deauth_next;
  logic [15:0] clen;

  wfcf_ram #(
    .WIDTH(96),
    .DEPTH(SESSION_SLOTS)
  ) u_sessions (
    .clk    (clk),
    .wr_en  (cmd.m1_write),
    .wr_addr(slot_ptr),
    .wr_data({ap, sta}),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_comb begin
    hlen = (f_to_ds && f_from_ds) ? HDR_FOUR_ADDR : HDR_THREE_ADDR;
    if (f_sub[3]) begin
      hlen = hlen + HDR_QOS_EXTRA;
    end
    eapol_ok = (f_type == TYPE_DATA) && (f_len > 12'(hlen + LLC_SNAP_BYTES))
               && (f_etype == EAPOL_ETHERTYPE);
    key_ok = f_len >= 12'(hlen + LLC_SNAP_BYTES + KEY_MIN_BYTES);
    ack = (f_info & KEY_ACK_MASK) != 16'd0;
    mic = (f_info & KEY_MIC_MASK) != 16'd0;
    is_m1 = ack && !mic;
    is_m2 = !ack && mic;
    ap = f_from_ds ? f_a2 : f_a1;
    sta = f_from_ds ? f_a1 : f_a2;
    deauth = (f_type == TYPE_MGMT) && (f_sub == SUB_DEAUTH);
    keep = 1'b0;
    unique case (capture_mode)
      MODE_RAW:    keep = 1'b1;
      MODE_BEACON: keep = (f_type == TYPE_MGMT) && (f_sub == SUB_BEACON);
      MODE_PROBE:  keep = (f_type == TYPE_MGMT) && (f_sub == SUB_PROBE_REQ);
      MODE_EAPOL:  keep = eapol_ok;
      MODE_PMKID:  keep = eapol_ok && f_pmkid;
      default:     keep = 1'b0;
    endcase
    addr_match = slot_valid[idx] ? (rd_data == {ap, sta}) : (ap == 48'd0 && sta == 48'd0);
    kept_next = keep ? kept_count + 32'd1 : kept_count;
    deauth_next = deauth ? deauth_count + 32'd1 : deauth_count;
    clen = (16'(f_len) > snap_length) ? snap_length : 16'(f_len);
  end

  always_comb begin
    st.follow = ((capture_mode == MODE_EAPOL) || (capture_mode == MODE_PMKID))
                && eapol_ok && key_ok && (is_m1 || is_m2);
    st.is_m1 = is_m1;
    st.hit = addr_match && (is_m1 || slot_open[idx]);
    st.idx_last = idx == IDX_LAST;
    st.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      f_type <= frame_type;
      f_sub <= frame_subtype;
      f_to_ds <= to_distribution;
      f_from_ds <= from_distribution;
      f_a1 <= address_one;
      f_a2 <= address_two;
      f_len <= frame_length;
      f_etype <= llc_ethertype;
      f_info <= key_word;
      f_pmkid <= pmkid_present;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.finish) begin
      keep_frame <= keep;
      capture_length <= keep ? clen : 16'd0;
      deauth_total <= deauth_next;
      captured_total <= kept_next;
      handshake_seen <= handshake_flag;
      handshake_ap <= handshake_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_mode <= MODE_RESET;
      snap_length <= SNAP_RESET;
      kept_count <= '0;
      deauth_count <= '0;
      handshake_flag <= 1'b0;
      handshake_address <= '0;
      slot_ptr <= '0;
      slot_valid <= '0;
      slot_open <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAPTURE_MODE: capture_mode <= cfg_data[2:0];
          REG_SNAP_LENGTH:  snap_length <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.set_open) begin
        slot_open[idx] <= 1'b1;
      end
      if (cmd.clr_open) begin
        slot_open[idx] <= 1'b0;
        if (!handshake_flag) begin
          handshake_flag <= 1'b1;
          handshake_address <= ap;
        end
      end
      if (cmd.m1_write) begin
        slot_valid[slot_ptr] <= 1'b1;
        slot_open[slot_ptr] <= 1'b1;
      end
      if (cmd.finish) begin
        kept_count <= kept_next;
        deauth_count <= deauth_next;
        if (keep) begin
          slot_ptr <= (slot_ptr == IDX_LAST) ? '0 : slot_ptr + IDX_W'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/wifi_frame_capture_filter.sv
// Top level of the wifi frame capture filter: unpacks the streams and joins
// the controller and datapath. Depends on wfcf_pkg, wfcf_ctrl and wfcf_datapath.
//
// Channel  | Signals                                   | Item
// s_axis   | s_axis_tvalid, s_axis_tready, s_axis_tdata | header fields of one frame
// m_axis   | m_axis_tvalid, m_axis_tready, m_axis_tdata | verdict, length and counters
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// A frame that is not an EAPOL M1 or M2 in EAPOL or PMKID mode goes from acceptance
// via the decide and finish states to its result. Such an M1 or M2 frame scans the
// session table slot by slot (read, then compare) through the single RAM read port.
// Reset clears all sessions at once through per-slot valid bits.
// A new item is taken while a finished result still waits on m_axis.
module wifi_frame_capture_filter import wfcf_pkg::*; #(
  parameter int SESSION_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // frame_type, frame_subtype, to_distribution, from_distribution, address_one,
  // address_two, frame_length, llc_ethertype, key_word, pmkid_present, zero fill
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // keep_frame, capture_length, deauth_total, captured_total, handshake_seen,
  // handshake_ap, zero fill
  output logic [135:0] m_axis_tdata
);

  cmd_t        cmd;
  status_t     st;
  logic        keep_frame;
  logic [15:0] capture_length;
  logic [31:0] deauth_total;
  logic [31:0] captured_total;
  logic        handshake_seen;
  logic [47:0] handshake_ap;

  assign cfg_ready = 1'b1;

  wfcf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  wfcf_datapath #(
    .SESSION_SLOTS(SESSION_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .frame_type       (s_axis_tdata[1:0]),
    .frame_subtype    (s_axis_tdata[5:2]),
    .to_distribution  (s_axis_tdata[6]),
    .from_distribution(s_axis_tdata[7]),
    .address_one      (s_axis_tdata[55:8]),
    .address_two      (s_axis_tdata[103:56]),
    .frame_length     (s_axis_tdata[115:104]),
    .llc_ethertype    (s_axis_tdata[131:116]),
    .key_word         (s_axis_tdata[147:132]),
    .pmkid_present    (s_axis_tdata[148]),
    .cmd              (cmd),
    .st               (st),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .keep_frame       (keep_frame),
    .capture_length   (capture_length),
    .deauth_total     (deauth_total),
    .captured_total   (captured_total),
    .handshake_seen   (handshake_seen),
    .handshake_ap     (handshake_ap)
  );

  assign m_axis_tdata = {6'd0, handshake_ap, handshake_seen, captured_total,
                         deauth_total, capture_length, keep_frame};

endmodule

### tb/tb_wifi_frame_capture_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for wifi_frame_capture_filter: a verdict board predicts every result.
// Frames and register writes are driven over the stream and config ports, with random stalls.
// Depends on wfcf_pkg and the wifi_frame_capture_filter RTL.

import wfcf_pkg::*;

localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
localparam logic [2:0] MODE_SPARE_MID = 3'd6;
localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

typedef struct {
  logic [1:0]  ftype;
  logic [3:0]  subtype;
  logic        to_ds;
  logic        from_ds;
  logic [47:0] addr1;
  logic [47:0] addr2;
  logic [11:0] flen;
  logic [15:0] ethertype;
  logic [15:0] key_word;
  logic        pmkid;
} frame_t;

typedef struct {
  logic        keep;
  logic [15:0] length;
  logic [31:0] deauths;
  logic [31:0] kept;
  logic        seen;
  logic [47:0] ap;
} verdict_t;

class capture_verdict_board #(int SLOTS = 16);
  logic [2:0]  mode;
  logic [15:0] snap;
  logic [47:0] sess_ap [SLOTS];
  logic [47:0] sess_sta [SLOTS];
  bit          sess_open [SLOTS];
  logic [31:0] kept_total;
  logic [31:0] deauth_total;
  bit          hs_seen;
  logic [47:0] hs_ap;
  verdict_t    verdicts_due[$];
  int          errors;
  int          checked;

  function new();
    mode = MODE_RESET;
    snap = SNAP_RESET;
    kept_total = 0;
    deauth_total = 0;
    hs_seen = 0;
    hs_ap = 0;
    errors = 0;
    checked = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sess_ap[i] = 0;
      sess_sta[i] = 0;
      sess_open[i] = 0;
    end
  endfunction

  function void write_reg(logic idx, logic [31:0] data);
    if (idx == REG_CAPTURE_MODE) begin
      mode = data[2:0];
    end else begin
      snap = data[15:0];
    end
  endfunction

  function void update_sessions(logic [47:0] ap, logic [47:0] sta, logic [15:0] info);
    logic ack;
    logic mic;
    int   slot;
    ack = (info & KEY_ACK_MASK) != 0;
    mic = (info & KEY_MIC_MASK) != 0;
    slot = -1;
    if (ack && !mic) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && sess_ap[i] == ap && sess_sta[i] == sta) slot = i;
      end
      if (slot < 0) begin
        slot = kept_total % SLOTS;
        sess_ap[slot] = ap;
        sess_sta[slot] = sta;
      end
      sess_open[slot] = 1;
    end else if (!ack && mic) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && sess_open[i] && sess_ap[i] == ap && sess_sta[i] == sta) slot = i;
      end
      if (slot >= 0) begin
        if (!hs_seen) begin
          hs_ap = ap;
          hs_seen = 1;
        end
        sess_open[slot] = 0;
      end
    end
  endfunction

  function void note_frame(frame_t f);
    int          hlen;
    verdict_t    v;
    logic [47:0] ap;
    logic [47:0] sta;
    hlen = (f.to_ds && f.from_ds) ? HDR_FOUR_ADDR : HDR_THREE_ADDR;
    if (f.subtype[3]) hlen += HDR_QOS_EXTRA;
    if (f.ftype == TYPE_MGMT && f.subtype == SUB_DEAUTH) deauth_total++;
    v.keep = 0;
    case (mode)
      MODE_RAW: v.keep = 1;
      MODE_BEACON: v.keep = (f.ftype == TYPE_MGMT && f.subtype == SUB_BEACON);
      MODE_PROBE: v.keep = (f.ftype == TYPE_MGMT && f.subtype == SUB_PROBE_REQ);
      MODE_EAPOL, MODE_PMKID: begin
        if (f.ftype == TYPE_DATA && f.flen > hlen + LLC_SNAP_BYTES &&
            f.ethertype == EAPOL_ETHERTYPE) begin
          if (f.flen >= hlen + LLC_SNAP_BYTES + KEY_MIN_BYTES) begin
            ap = f.from_ds ? f.addr2 : f.addr1;
            sta = f.from_ds ? f.addr1 : f.addr2;
            update_sessions(ap, sta, f.key_word);
          end
          v.keep = (mode == MODE_EAPOL) ? 1'b1 : f.pmkid;
        end
      end
      default: v.keep = 0;
    endcase
    v.length = 0;
    if (v.keep) begin
      v.length = (f.flen > snap) ? snap : 16'(f.flen);
      kept_total++;
    end
    v.deauths = deauth_total;
    v.kept = kept_total;
    v.seen = hs_seen;
    v.ap = hs_ap;
    verdicts_due.push_back(v);
  endfunction

  function void compare(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 30) begin
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
    end
  endfunction

  function void check_verdict(logic [135:0] d);
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      errors++;
      if (errors <= 30) begin
        $display("%0t ns: result with no frame pending, expected none, got %h", $time, d);
      end
      return;
    end
    want = verdicts_due.pop_front();
    checked++;
    compare("keep_frame", want.keep, d[0]);
    compare("capture_length", want.length, d[16:1]);
    compare("deauth_total", want.deauths, d[48:17]);
    compare("captured_total", want.kept, d[80:49]);
    compare("handshake_seen", want.seen, d[81]);
    compare("handshake_ap", want.ap, d[129:82]);
    compare("zero fill", 0, d[135:130]);
  endfunction
endclass

module tb_wifi_frame_capture_filter;
  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 3 + 2 * SLOTS + 8;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 75;
  localparam logic [2:0] PHASE_MODES [PHASES] = '{
    MODE_EAPOL, MODE_RAW, MODE_PMKID, MODE_BEACON, MODE_EAPOL, MODE_PROBE,
    MODE_PMKID, MODE_SPARE_LO, MODE_EAPOL, MODE_SPARE_MID, MODE_PMKID, MODE_SPARE_HI
  };

  logic         clk = 0;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  capture_verdict_board #(SLOTS) board;
  logic [47:0] ap_pool [4];
  logic [47:0] sta_pool [6];
  bit          steady;
  int          hold_request;
  int          hold_cycles;
  int          settings_used;
  int          sent;
  int          cycles = 0;

  wifi_frame_capture_filter #(.SESSION_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [151:0] pack_frame(frame_t f);
    return {3'b0, f.pmkid, f.key_word, f.ethertype, f.flen, f.addr2, f.addr1,
            f.from_ds, f.to_ds, f.subtype, f.ftype};
  endfunction

  function automatic frame_t unpack_frame(logic [151:0] d);
    frame_t f;
    f.ftype = d[1:0];
    f.subtype = d[5:2];
    f.to_ds = d[6];
    f.from_ds = d[7];
    f.addr1 = d[55:8];
    f.addr2 = d[103:56];
    f.flen = d[115:104];
    f.ethertype = d[131:116];
    f.key_word = d[147:132];
    f.pmkid = d[148];
    return f;
  endfunction

  function automatic frame_t make_frame(logic [1:0] ftype, logic [3:0] subtype, logic to_ds,
                                        logic from_ds, logic [47:0] addr1, logic [47:0] addr2,
                                        logic [11:0] flen, logic [15:0] ethertype,
                                        logic [15:0] key_word, logic pmkid);
    frame_t f;
    f.ftype = ftype;
    f.subtype = subtype;
    f.to_ds = to_ds;
    f.from_ds = from_ds;
    f.addr1 = addr1;
    f.addr2 = addr2;
    f.flen = flen;
    f.ethertype = ethertype;
    f.key_word = key_word;
    f.pmkid = pmkid;
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [47:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic frame_t random_frame();
    return make_frame(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      rand_addr(), rand_addr(), 12'($urandom_range(0, 4095)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
  endfunction

  function automatic frame_t mgmt_frame();
    frame_t f;
    f = random_frame();
    f.ftype = TYPE_MGMT;
    case ($urandom_range(0, 3))
      0: f.subtype = SUB_BEACON;
      1: f.subtype = SUB_PROBE_REQ;
      2: f.subtype = SUB_DEAUTH;
      default: f.subtype = f.subtype;
    endcase
    return f;
  endfunction

  // Addresses come from small pools so that M1 and M2 frames meet the same sessions,
  // and there are more pairs than slots so that entries get replaced.
  function automatic frame_t eapol_frame();
    frame_t      f;
    logic [47:0] ap;
    logic [47:0] sta;
    int          hlen;
    int          r;
    f = random_frame();
    f.ftype = TYPE_DATA;
    f.ethertype = EAPOL_ETHERTYPE;
    ap = ($urandom_range(0, 19) == 0) ? 48'd0 : ap_pool[$urandom_range(0, 3)];
    sta = ($urandom_range(0, 19) == 0) ? 48'd0 : sta_pool[$urandom_range(0, 5)];
    if (f.from_ds) begin
      f.addr1 = sta;
      f.addr2 = ap;
    end else begin
      f.addr1 = ap;
      f.addr2 = sta;
    end
    hlen = (f.to_ds && f.from_ds) ? HDR_FOUR_ADDR : HDR_THREE_ADDR;
    if (f.subtype[3]) hlen += HDR_QOS_EXTRA;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      f.flen = 12'(hlen + LLC_SNAP_BYTES + KEY_MIN_BYTES + $urandom_range(0, 400));
    end else if (r < 95) begin
      f.flen = 12'(hlen + LLC_SNAP_BYTES + $urandom_range(1, 6));
    end else begin
      f.flen = 12'(hlen + $urandom_range(0, 8));
    end
    f.key_word &= ~(KEY_ACK_MASK | KEY_MIC_MASK);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      f.key_word |= KEY_ACK_MASK;
    end else if (r < 8) begin
      f.key_word |= KEY_MIC_MASK;
    end else if (r < 9) begin
      f.key_word |= KEY_ACK_MASK | KEY_MIC_MASK;
    end
    return f;
  endfunction

  function automatic frame_t next_random_frame(logic [2:0] mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_EAPOL || mode == MODE_PMKID) begin
      if (r < 70) return eapol_frame();
      if (r < 85) return mgmt_frame();
      return random_frame();
    end
    if (r < 35) return mgmt_frame();
    if (r < 50) return eapol_frame();
    return random_frame();
  endfunction

  task automatic send_frame(frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= pack_frame(f);
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 0;
    while (board.verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(logic [2:0] mode, logic [15:0] snap);
    logic [31:0] data;
    wait_idle();
    data = $urandom;
    data[2:0] = mode;
    write_reg(REG_CAPTURE_MODE, data);
    data = $urandom;
    data[15:0] = snap;
    write_reg(REG_SNAP_LENGTH, data);
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) board.note_frame(unpack_frame(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int run_left;
    int hold_left;
    run_left = 0;
    hold_left = 0;
    m_axis_tready = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_cycles++;
        m_axis_tready <= 0;
      end else if (steady) begin
        m_axis_tready <= 1;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1;
        run_left = $urandom_range(0, 15);
      end else begin
        m_axis_tready <= 0;
        run_left = pick_gap();
      end
    end
  end

  initial begin
    logic [15:0] snap;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    steady = 0;
    hold_request = 0;
    hold_cycles = 0;
    settings_used = 0;
    sent = 0;
    board = new();
    foreach (ap_pool[i]) ap_pool[i] = rand_addr();
    foreach (sta_pool[i]) sta_pool[i] = rand_addr();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    apply_setting(MODE_RAW, SNAP_RESET);
    send_frame(make_frame(TYPE_MGMT, 4'h0, 0, 0, '0, '0, '0, '0, '0, 0));
    send_frame(make_frame(2'b11, 4'hF, 1, 1, '1, '1, '1, '1, '1, 1));
    send_frame(make_frame(TYPE_MGMT, SUB_DEAUTH, 0, 0, ap_pool[0], sta_pool[0], 12'd38,
                          '0, '0, 0));
    send_frame(make_frame(TYPE_MGMT, SUB_BEACON, 0, 0, '1, ap_pool[0], 12'd200, '0, '0, 0));
    send_frame(make_frame(TYPE_MGMT, SUB_PROBE_REQ, 0, 0, '1, sta_pool[0], 12'd60,
                          '0, '0, 0));
    send_frame(make_frame(TYPE_DATA, SUB_DEAUTH, 0, 0, ap_pool[0], sta_pool[0], 12'd80,
                          '0, '0, 0));

    apply_setting(MODE_BEACON, 16'd0);
    send_frame(make_frame(TYPE_MGMT, SUB_BEACON, 0, 0, '1, ap_pool[1], '1, '0, '0, 0));
    send_frame(make_frame(TYPE_MGMT, SUB_PROBE_REQ, 0, 0, '1, sta_pool[1], 12'd90,
                          '0, '0, 0));

    apply_setting(MODE_PROBE, 16'd100);
    send_frame(make_frame(TYPE_MGMT, SUB_PROBE_REQ, 0, 0, '1, sta_pool[2], '1, '0, '0, 0));
    send_frame(make_frame(TYPE_MGMT, SUB_BEACON, 0, 0, '1, ap_pool[2], 12'd150, '0, '0, 0));

    // The zero-address M1 refreshes a never-used slot; the M2 that follows has no open M1.
    apply_setting(MODE_EAPOL, SNAP_RESET);
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, '0, '0, 12'd120, EAPOL_ETHERTYPE,
                          KEY_ACK_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[1], sta_pool[1], 12'd120,
                          EAPOL_ETHERTYPE, KEY_MIC_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[1], sta_pool[1], 12'd120,
                          EAPOL_ETHERTYPE, 16'h000A, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[2], sta_pool[2], 12'd120,
                          EAPOL_ETHERTYPE, KEY_ACK_MASK | KEY_MIC_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[3], sta_pool[3], 12'd32,
                          EAPOL_ETHERTYPE, KEY_ACK_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[3], sta_pool[3], 12'd38,
                          EAPOL_ETHERTYPE, KEY_ACK_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 0, ap_pool[3], sta_pool[3], 12'd120,
                          16'h0800, KEY_ACK_MASK, 0));
    send_frame(make_frame(TYPE_DATA, 4'h8, 1, 1, sta_pool[4], ap_pool[3], 12'd47,
                          EAPOL_ETHERTYPE, KEY_ACK_MASK, 1));

    apply_setting(MODE_PMKID, 16'd64);
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 1, sta_pool[5], ap_pool[0], 12'd120,
                          EAPOL_ETHERTYPE, 16'h0000, 1));
    send_frame(make_frame(TYPE_DATA, 4'h0, 0, 1, sta_pool[5], ap_pool[0], 12'd120,
                          EAPOL_ETHERTYPE, 16'h0000, 0));

    apply_setting(MODE_SPARE_LO, 16'd0);
    send_frame(make_frame(TYPE_MGMT, SUB_BEACON, 0, 0, '1, ap_pool[1], 12'd100, '0, '0, 0));
    apply_setting(MODE_SPARE_HI, SNAP_RESET);
    send_frame(make_frame(TYPE_MGMT, SUB_DEAUTH, 0, 0, ap_pool[1], sta_pool[1], 12'd40,
                          '0, '0, 0));

    for (int p = 0; p < PHASES; p++) begin
      case (p % 6)
        0: snap = SNAP_RESET;
        1: snap = 16'd0;
        2: snap = 16'($urandom_range(20, 200));
        3: snap = 16'd4095;
        4: snap = 16'($urandom_range(0, 65535));
        default: snap = 16'd4096;
      endcase
      apply_setting(PHASE_MODES[p], snap);
      steady = (p == 1);
      // A long hold on the result side makes the block back up and stall its input.
      if (p == 2) hold_request = 300;
      for (int k = 0; k < PHASE_ITEMS; k++) send_frame(next_random_frame(PHASE_MODES[p]));
    end
    steady = 0;

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d frames under %0d filter settings, %0d results compared.",
             sent, settings_used, board.checked);
    $display("Kept %0d frames, saw %0d deauths, handshake latched %0d, %0d hold cycles.",
             board.kept_total, board.deauth_total, board.hs_seen, hold_cycles);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
